[sv/itf_pkg.sv]
package itf_pkg;

	localparam int VALUE_W  = 32;
	localparam int RADIX_W  = 6;
	localparam int FWIDTH_W = 7;
	localparam int MDIG_W   = 6;
	localparam int FLAGS_W  = 7;
	localparam int CHAR_W   = 8;

	// format flag bit positions
	localparam int FL_ZERO  = 0;
	localparam int FL_SIGN  = 1;
	localparam int FL_PLUS  = 2;
	localparam int FL_SPACE = 3;
	localparam int FL_LEFT  = 4;
	localparam int FL_PREF  = 5;
	localparam int FL_LOWER = 6;

	localparam logic [RADIX_W-1:0] MIN_RADIX = 6'd2;
	localparam logic [RADIX_W-1:0] MAX_RADIX = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
	localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
	// digit code whose glyph is the hex prefix letter
	localparam logic [RADIX_W-1:0] HEX_MARK  = 6'd33;

	// divider: quotient bits retired per cycle
	localparam int BITS_PER_STEP = 8;
	localparam int DIV_STEPS     = VALUE_W / BITS_PER_STEP;
	localparam int STEP_W        = $clog2(DIV_STEPS);

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;

	// text segments in output order
	typedef enum logic [2:0] {
		PH_LEAD,
		PH_SIGN,
		PH_PRE0,
		PH_PREX,
		PH_ZPAD,
		PH_PZERO,
		PH_DIGIT,
		PH_TRAIL
	} phase_t;

	localparam int NUM_PHASES = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_PICK,
		ST_EMIT,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic   load;
		logic   div_step;
		logic   size;
		logic   emit;
		logic   err;
		logic   last;
		phase_t phase;
	} itf_cmd_t;

	typedef struct packed {
		logic                  bad;
		logic                  div_last;
		logic                  quo_zero;
		logic                  out_free;
		logic [NUM_PHASES-1:0] en;
		logic                  pad_one;
		logic                  zcnt_one;
		logic                  depth_one;
	} itf_stat_t;

	function automatic logic [CHAR_W-1:0] digit_char(logic [RADIX_W-1:0] d, logic lower);
		logic [CHAR_W-1:0] c;
		if (d < 6'd10) begin
			c = CH_ZERO + {2'b00, d};
		end else if (lower) begin
			c = CH_LC_A + {2'b00, d} - 8'd10;
		end else begin
			c = CH_UC_A + {2'b00, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

[sv/itf_if.sv]
interface itf_in_if import itf_pkg::*;;
	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  value;
	logic [RADIX_W-1:0]  radix;
	logic [FWIDTH_W-1:0] min_width;
	logic [MDIG_W-1:0]   min_digits;
	logic [FLAGS_W-1:0]  format_flags;

	modport source (
		output valid, value, radix, min_width, min_digits, format_flags,
		input  ready
	);
	modport sink (
		input  valid, value, radix, min_width, min_digits, format_flags,
		output ready
	);
endinterface

interface itf_out_if import itf_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] text_char;
	logic              last_char;
	logic              bad_radix;

	modport source (
		output valid, text_char, last_char, bad_radix,
		input  ready
	);
	modport sink (
		input  valid, text_char, last_char, bad_radix,
		output ready
	);
endinterface

[sv/itf_ctrl.sv]
module itf_ctrl import itf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  itf_stat_t stat,
	output itf_cmd_t  cmd
);

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic       seg_end;
	logic [3:0] from_idx;
	logic [3:0] nxt;

	// lowest enabled segment at or above p, 8 when none
	function automatic logic [3:0] first_from(logic [NUM_PHASES-1:0] en, logic [3:0] p);
		logic [3:0] r;
		r = 4'd8;
		for (int i = NUM_PHASES - 1; i >= 0; i--) begin
			if (en[i] && (4'(i) >= p)) begin
				r = 4'(i);
			end
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_LEAD;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		cmd       = '0;
		cmd.phase = phase_q;
		in_ready  = 1'b0;

		case (phase_q)
			PH_LEAD, PH_ZPAD, PH_TRAIL: seg_end = stat.pad_one;
			PH_PZERO:                   seg_end = stat.zcnt_one;
			PH_DIGIT:                   seg_end = stat.depth_one;
			default:                    seg_end = 1'b1;
		endcase

		from_idx = (state_q == ST_PICK) ? 4'd0 : ({1'b0, phase_q} + 4'd1);
		nxt      = first_from(stat.en, from_idx);

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				if (stat.bad) begin
					state_d = ST_ERR;
				end else begin
					cmd.div_step = 1'b1;
					if (stat.div_last && stat.quo_zero) begin
						state_d = ST_SIZE;
					end
				end
			end
			ST_SIZE: begin
				cmd.size = 1'b1;
				state_d  = ST_PICK;
			end
			ST_PICK: begin
				// the digit segment is always enabled
				phase_d = phase_t'(nxt[2:0]);
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (seg_end) begin
						if (nxt[3]) begin
							cmd.last = 1'b1;
							state_d  = ST_IDLE;
						end else begin
							phase_d = phase_t'(nxt[2:0]);
						end
					end
				end
			end
			ST_ERR: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.err  = 1'b1;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[sv/itf_datapath.sv]
module itf_datapath import itf_pkg::*; #(
	parameter int MAX_OUT     = 64,
	parameter int DIGIT_SLOTS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [VALUE_W-1:0]  value,
	input  logic [RADIX_W-1:0]  radix,
	input  logic [FWIDTH_W-1:0] min_width,
	input  logic [MDIG_W-1:0]   min_digits,
	input  logic [FLAGS_W-1:0]  format_flags,
	input  itf_cmd_t            cmd,
	output itf_stat_t           stat,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [CHAR_W-1:0]   text_char,
	output logic                last_char,
	output logic                bad_radix
);

	localparam int DEPTH_W = $clog2(DIGIT_SLOTS + 1);
	localparam logic [FWIDTH_W-1:0] WIDTH_CAP = FWIDTH_W'(MAX_OUT);
	localparam logic [MDIG_W-1:0]   PREC_CAP  = MDIG_W'(MAX_OUT - 3);
	localparam logic [DEPTH_W-1:0]  DEPTH_ONE = DEPTH_W'(1);
	localparam logic [STEP_W-1:0]   STEP_LAST = STEP_W'(DIV_STEPS - 1);
	localparam logic [STEP_W-1:0]   STEP_ONE  = STEP_W'(1);

	// captured word
	logic [RADIX_W-1:0]  base_q;
	logic [FWIDTH_W-1:0] width_q;
	logic [MDIG_W-1:0]   prec_q;
	logic                zero_q, left_q, pref_q, lower_q, has_sign_q;
	logic [CHAR_W-1:0]   sign_char_q;
	logic                bad_q;

	// divider
	logic [VALUE_W-1:0]  div_q;
	logic [RADIX_W-1:0]  rem_q;
	logic [STEP_W-1:0]   step_q;
	logic [VALUE_W-1:0]  div_n;
	logic [RADIX_W-1:0]  rem_n;
	logic [RADIX_W:0]    trial;

	// digit stack, top at entry 0
	logic [RADIX_W-1:0]  stk_q [DIGIT_SLOTS];
	logic [DEPTH_W-1:0]  depth_q;

	// segment counters
	logic [FWIDTH_W-1:0]   pad_q;
	logic [MDIG_W-1:0]     zcnt_q;
	logic [NUM_PHASES-1:0] en_q;

	logic                out_valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q, bad_out_q;

	// load-side logic
	logic                neg_in, left_in;
	logic [VALUE_W-1:0]  mag_in;
	logic [CHAR_W-1:0]   sign_in;
	logic                has_sign_in;

	// sizing logic
	logic [MDIG_W-1:0]     nd;
	logic [MDIG_W-1:0]     prec_eff, zc_n;
	logic [1:0]            pref_len;
	logic [FWIDTH_W-1:0]   content, pad_n;
	logic [NUM_PHASES-1:0] en_n;

	logic [CHAR_W-1:0]   char_n;
	logic                div_last;
	logic                push, pop;

	always_comb begin
		neg_in  = format_flags[FL_SIGN] & value[VALUE_W-1];
		mag_in  = neg_in ? (VALUE_W'(0) - value) : value;
		left_in = format_flags[FL_LEFT];
		has_sign_in = 1'b1;
		if (neg_in) begin
			sign_in = CH_MINUS;
		end else if (format_flags[FL_PLUS]) begin
			sign_in = CH_PLUS;
		end else if (format_flags[FL_SPACE]) begin
			sign_in = CH_SPACE;
		end else begin
			sign_in     = CH_NUL;
			has_sign_in = 1'b0;
		end
	end

	// restoring division, BITS_PER_STEP quotient bits per cycle
	always_comb begin
		rem_n = rem_q;
		div_n = div_q;
		trial = '0;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			trial = {rem_n, div_n[VALUE_W-1]};
			div_n = {div_n[VALUE_W-2:0], 1'b0};
			if (trial >= {1'b0, base_q}) begin
				rem_n    = RADIX_W'(trial - {1'b0, base_q});
				div_n[0] = 1'b1;
			end else begin
				rem_n = trial[RADIX_W-1:0];
			end
		end
	end

	assign div_last = (step_q == STEP_LAST);
	assign push     = cmd.div_step & div_last;
	assign pop      = cmd.emit & ~cmd.err & (cmd.phase == PH_DIGIT);

	always_comb begin
		nd       = MDIG_W'(depth_q);
		prec_eff = (prec_q > nd) ? prec_q : nd;
		zc_n     = (prec_q > nd) ? (prec_q - nd) : '0;
		if (pref_q && (base_q == RADIX_HEX)) begin
			pref_len = 2'd2;
		end else if (pref_q && (base_q == RADIX_OCT)) begin
			pref_len = 2'd1;
		end else begin
			pref_len = 2'd0;
		end
		content = FWIDTH_W'(has_sign_q) + FWIDTH_W'(pref_len) + FWIDTH_W'(prec_eff);
		pad_n   = (width_q > content) ? (width_q - content) : '0;
		en_n           = '0;
		en_n[PH_LEAD]  = ~zero_q & ~left_q & (pad_n != '0);
		en_n[PH_SIGN]  = has_sign_q;
		en_n[PH_PRE0]  = pref_len != 2'd0;
		en_n[PH_PREX]  = pref_len == 2'd2;
		en_n[PH_ZPAD]  = zero_q & (pad_n != '0);
		en_n[PH_PZERO] = zc_n != '0;
		en_n[PH_DIGIT] = 1'b1;
		en_n[PH_TRAIL] = left_q & (pad_n != '0);
	end

	always_comb begin
		case (cmd.phase)
			PH_LEAD:  char_n = CH_SPACE;
			PH_SIGN:  char_n = sign_char_q;
			PH_PRE0:  char_n = CH_ZERO;
			PH_PREX:  char_n = digit_char(HEX_MARK, lower_q);
			PH_ZPAD:  char_n = CH_ZERO;
			PH_PZERO: char_n = CH_ZERO;
			PH_DIGIT: char_n = digit_char(stk_q[0], lower_q);
			PH_TRAIL: char_n = CH_SPACE;
			default:  char_n = CH_SPACE;
		endcase
		if (cmd.err) begin
			char_n = CH_NUL;
		end
	end

	// captured word and divider payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q      <= radix;
			width_q     <= (min_width > WIDTH_CAP) ? WIDTH_CAP : min_width;
			prec_q      <= (min_digits > PREC_CAP) ? PREC_CAP : min_digits;
			left_q      <= left_in;
			zero_q      <= format_flags[FL_ZERO] & ~left_in;
			pref_q      <= format_flags[FL_PREF];
			lower_q     <= format_flags[FL_LOWER];
			has_sign_q  <= has_sign_in;
			sign_char_q <= sign_in;
			div_q       <= mag_in;
		end else if (cmd.div_step) begin
			div_q <= div_n;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			stk_q[0] <= rem_n;
			for (int i = 1; i < DIGIT_SLOTS; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end else if (pop) begin
			for (int i = 0; i < DIGIT_SLOTS - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q   <= 1'b0;
			rem_q   <= '0;
			step_q  <= '0;
			depth_q <= '0;
			pad_q   <= '0;
			zcnt_q  <= '0;
			en_q    <= '0;
		end else begin
			if (cmd.load) begin
				bad_q   <= (radix < MIN_RADIX) || (radix > MAX_RADIX);
				rem_q   <= '0;
				step_q  <= '0;
				depth_q <= '0;
			end else if (cmd.div_step) begin
				if (div_last) begin
					rem_q   <= '0;
					step_q  <= '0;
					depth_q <= depth_q + DEPTH_ONE;
				end else begin
					rem_q  <= rem_n;
					step_q <= step_q + STEP_ONE;
				end
			end else if (pop) begin
				depth_q <= depth_q - DEPTH_ONE;
			end

			if (cmd.size) begin
				pad_q  <= pad_n;
				zcnt_q <= zc_n;
				en_q   <= en_n;
			end else if (cmd.emit && !cmd.err) begin
				case (cmd.phase)
					PH_LEAD, PH_ZPAD, PH_TRAIL: pad_q  <= pad_q - FWIDTH_W'(1);
					PH_PZERO:                   zcnt_q <= zcnt_q - MDIG_W'(1);
					default:                    ;
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q    <= char_n;
			last_q    <= cmd.last;
			bad_out_q <= cmd.err;
		end
	end

	always_comb begin
		stat           = '0;
		stat.bad       = bad_q;
		stat.div_last  = div_last;
		stat.quo_zero  = (div_n == '0);
		stat.out_free  = ~out_valid_q | out_ready;
		stat.en        = en_q;
		stat.pad_one   = (pad_q == FWIDTH_W'(1));
		stat.zcnt_one  = (zcnt_q == MDIG_W'(1));
		stat.depth_one = (depth_q == DEPTH_ONE);
	end

	assign out_valid = out_valid_q;
	assign text_char = char_q;
	assign last_char = last_q;
	assign bad_radix = bad_out_q;

endmodule

[sv/integer_to_text_formatter_unit.sv]
// printf-style integer formatter
// din takes one word: value, radix, min_width, min_digits and format_flags.
// dout returns the formatted text one character per word, last_char set on
// the final one. A radix outside 2 to 36 returns a single word with
// text_char 0, last_char and bad_radix set.
// the block captures the word, then divides out the digits one at a time
// in the shared divider (8 quotient bits per cycle), sizes the padding in
// the ST_SIZE and ST_PICK states, then sends one character per cycle while
// the output register is free. din is taken again once the last character
// sits in the output register, so the next word's conversion overlaps with
// the receiver taking that character.
// when dout.ready is low the character held in the output register stays
// put and generation pauses; nothing is dropped or repeated.
// reset clears the controller and the output valid; no word is in flight
// afterwards.
module integer_to_text_formatter_unit import itf_pkg::*; #(
	parameter int MAX_OUT     = 64,
	parameter int DIGIT_SLOTS = 32
) (
	input logic         clk,
	input logic         arst_n,
	itf_in_if.sink      din,
	itf_out_if.source   dout
);

	itf_cmd_t  cmd;
	itf_stat_t stat;

	itf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	itf_datapath #(
		.MAX_OUT     (MAX_OUT),
		.DIGIT_SLOTS (DIGIT_SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (din.value),
		.radix        (din.radix),
		.min_width    (din.min_width),
		.min_digits   (din.min_digits),
		.format_flags (din.format_flags),
		.cmd          (cmd),
		.stat         (stat),
		.out_ready    (dout.ready),
		.out_valid    (dout.valid),
		.text_char    (dout.text_char),
		.last_char    (dout.last_char),
		.bad_radix    (dout.bad_radix)
	);

endmodule

[test/itf_text_checker.sv]
module itf_text_checker import itf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	itf_in_if    din,
	itf_out_if   dout,
	output int   fail_count,
	output int   pending,
	output int   char_count
);

	localparam int TEXT_MAX    = 64;
	localparam int DIGITS_MAX  = 32;
	localparam int PREC_MAX    = TEXT_MAX - 3;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              bad;
	} text_word_t;

	text_word_t text_q[$];
	int         n_fail;
	int         n_chars;

	// builds the expected text of one number and queues it word by word
	function automatic void format_number(
		input logic [VALUE_W-1:0]  value,
		input logic [RADIX_W-1:0]  radix,
		input logic [FWIDTH_W-1:0] min_width,
		input logic [MDIG_W-1:0]   min_digits,
		input logic [FLAGS_W-1:0]  flags_in
	);
		string              glyphs;
		logic [FLAGS_W-1:0] flags;
		logic [VALUE_W-1:0] mag;
		logic [CHAR_W-1:0]  sign_ch;
		logic [CHAR_W-1:0]  pad_ch;
		logic               has_sign;
		logic [CHAR_W-1:0]  digs[$];
		logic [CHAR_W-1:0]  text[$];
		int                 width;
		int                 prec;
		int                 nd;
		int                 n;
		text_word_t         w;

		flags = flags_in;
		width = (int'(min_width) > TEXT_MAX) ? TEXT_MAX : int'(min_width);
		prec  = (int'(min_digits) > PREC_MAX) ? PREC_MAX : int'(min_digits);
		if (flags[FL_LEFT]) flags[FL_ZERO] = 1'b0;

		if (radix < MIN_RADIX || radix > MAX_RADIX) begin
			w = '{ch: CH_NUL, last: 1'b1, bad: 1'b1};
			text_q.push_back(w);
			return;
		end

		glyphs = flags[FL_LOWER] ? "0123456789abcdefghijklmnopqrstuvwxyz"
		                         : "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
		pad_ch = flags[FL_ZERO] ? CH_ZERO : CH_SPACE;

		mag      = value;
		has_sign = 1'b1;
		sign_ch  = CH_NUL;
		if (flags[FL_SIGN] && value[VALUE_W-1]) begin
			sign_ch = CH_MINUS;
			mag     = -value;
		end else if (flags[FL_PLUS]) begin
			sign_ch = CH_PLUS;
		end else if (flags[FL_SPACE]) begin
			sign_ch = CH_SPACE;
		end else begin
			has_sign = 1'b0;
		end
		if (has_sign) width--;
		if (flags[FL_PREF]) begin
			if (radix == RADIX_HEX) width -= 2;
			else if (radix == RADIX_OCT) width--;
		end

		// most significant digit ends up at the front
		if (mag == '0) begin
			digs.push_back(CH_ZERO);
		end else begin
			while (mag != '0 && digs.size() < DIGITS_MAX) begin
				digs.push_front(glyphs[mag % radix]);
				mag = mag / radix;
			end
		end
		nd = digs.size();
		if (nd > prec) prec = nd;
		width -= prec;

		if (!flags[FL_ZERO] && !flags[FL_LEFT]) begin
			while (width > 0) begin
				text.push_back(CH_SPACE);
				width--;
			end
		end
		if (has_sign) text.push_back(sign_ch);
		if (flags[FL_PREF] && (radix == RADIX_OCT || radix == RADIX_HEX))
			text.push_back(CH_ZERO);
		if (flags[FL_PREF] && radix == RADIX_HEX)
			text.push_back(glyphs[HEX_MARK]);
		if (!flags[FL_LEFT]) begin
			while (width > 0) begin
				text.push_back(pad_ch);
				width--;
			end
		end
		for (int k = nd; k < prec; k++) text.push_back(CH_ZERO);
		foreach (digs[k]) text.push_back(digs[k]);
		while (width > 0) begin
			text.push_back(CH_SPACE);
			width--;
		end

		n = (text.size() > TEXT_MAX) ? TEXT_MAX : text.size();
		for (int k = 0; k < n; k++) begin
			w = '{ch: text[k], last: (k == n - 1), bad: 1'b0};
			text_q.push_back(w);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		text_word_t want;

		if (!arst_n) begin
			text_q.delete();
			n_fail = 0;
			n_chars = 0;
			fail_count <= 0;
			pending <= 0;
			char_count <= 0;
		end else begin
			if (dout.valid && dout.ready) begin
				n_chars++;
				if (text_q.size() == 0) begin
					n_fail++;
					if (n_fail <= REPORT_MAX)
						$display("%0t: word with no text expected: char %h last %b bad %b",
							$time, dout.text_char, dout.last_char, dout.bad_radix);
				end else begin
					want = text_q.pop_front();
					if (want.ch !== dout.text_char || want.last !== dout.last_char ||
					    want.bad !== dout.bad_radix) begin
						n_fail++;
						if (n_fail <= REPORT_MAX)
							$display("%0t: expected char %h last %b bad %b, got %h %b %b",
								$time, want.ch, want.last, want.bad,
								dout.text_char, dout.last_char, dout.bad_radix);
					end
				end
			end
			if (din.valid && din.ready)
				format_number(din.value, din.radix, din.min_width, din.min_digits,
					din.format_flags);
			fail_count <= n_fail;
			pending <= text_q.size();
			char_count <= n_chars;
		end
	end

endmodule

[test/tb_top.sv]
module tb_top import itf_pkg::*;;

	localparam int RESET_CYCLES = 12;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 300;

	localparam logic [FLAGS_W-1:0] M_ZERO  = FLAGS_W'(1 << FL_ZERO);
	localparam logic [FLAGS_W-1:0] M_SIGN  = FLAGS_W'(1 << FL_SIGN);
	localparam logic [FLAGS_W-1:0] M_PLUS  = FLAGS_W'(1 << FL_PLUS);
	localparam logic [FLAGS_W-1:0] M_SPACE = FLAGS_W'(1 << FL_SPACE);
	localparam logic [FLAGS_W-1:0] M_LEFT  = FLAGS_W'(1 << FL_LEFT);
	localparam logic [FLAGS_W-1:0] M_PREF  = FLAGS_W'(1 << FL_PREF);
	localparam logic [FLAGS_W-1:0] M_LOWER = FLAGS_W'(1 << FL_LOWER);
	localparam logic [FLAGS_W-1:0] M_ALL   = '1;

	logic clk = 1'b0;
	logic arst_n;
	logic hold_on = 1'b0;
	int   src_idle_pct = 0;
	int   snk_idle_pct = 0;
	int   n_sent = 0;
	int   fail_count;
	int   pending;
	int   char_count;
	event hold_go;

	always #2 clk = ~clk;

	itf_in_if  din_if();
	itf_out_if dout_if();

	integer_to_text_formatter_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	itf_text_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din_if),
		.dout       (dout_if),
		.fail_count (fail_count),
		.pending    (pending),
		.char_count (char_count)
	);

	// receiver pacing
	always @(posedge clk) begin
		if (!arst_n || hold_on)
			dout_if.ready <= 1'b0;
		else
			dout_if.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// long receiver hold-off so the block backs up into din
	initial forever begin
		@(hold_go);
		hold_on <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_on <= 1'b0;
	end

	task automatic offer_number(
		input logic [VALUE_W-1:0]  value,
		input logic [RADIX_W-1:0]  radix,
		input logic [FWIDTH_W-1:0] min_width,
		input logic [MDIG_W-1:0]   min_digits,
		input logic [FLAGS_W-1:0]  flags
	);
		while ($urandom_range(99) < src_idle_pct) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
		end
		din_if.valid        <= 1'b1;
		din_if.value        <= value;
		din_if.radix        <= radix;
		din_if.min_width    <= min_width;
		din_if.min_digits   <= min_digits;
		din_if.format_flags <= flags;
		@(posedge clk);
		while (!din_if.ready) @(posedge clk);
		n_sent++;
	endtask

	task automatic offer_random_number();
		logic [VALUE_W-1:0]  value;
		logic [RADIX_W-1:0]  radix;
		logic [FWIDTH_W-1:0] min_width;
		logic [MDIG_W-1:0]   min_digits;

		case ($urandom_range(9))
			0, 1: value = $urandom_range(0, 20);
			2: value = -VALUE_W'($urandom_range(1, 1000));
			3: begin
				case ($urandom_range(3))
					0: value = '0;
					1: value = 32'h8000_0000;
					2: value = 32'h7FFF_FFFF;
					default: value = '1;
				endcase
			end
			default: value = $urandom();
		endcase
		// mostly legal bases, the common ones weighted up
		if ($urandom_range(9) == 0) begin
			radix = RADIX_W'($urandom_range(0, 63));
		end else begin
			case ($urandom_range(5))
				0: radix = RADIX_OCT;
				1: radix = RADIX_HEX;
				2: radix = 6'd10;
				default: radix = RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX));
			endcase
		end
		min_width  = ($urandom_range(7) == 0) ? FWIDTH_W'($urandom_range(0, 127))
		                                      : FWIDTH_W'($urandom_range(0, 20));
		min_digits = ($urandom_range(7) == 0) ? MDIG_W'($urandom_range(0, 63))
		                                      : MDIG_W'($urandom_range(0, 10));
		offer_number(value, radix, min_width, min_digits, FLAGS_W'($urandom_range(0, 127)));
	endtask

	// lets pending update first so the word just accepted is counted in it
	task automatic wait_text_drained();
		din_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		arst_n              <= 1'b0;
		din_if.valid        <= 1'b0;
		din_if.value        <= '0;
		din_if.radix        <= '0;
		din_if.min_width    <= '0;
		din_if.min_digits   <= '0;
		din_if.format_flags <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 35;
		snk_idle_pct = 58;
		offer_number(32'd0, 6'd10, 7'd0, 6'd0, '0);
		offer_number(32'hFFFF_FFFF, 6'd10, 7'd0, 6'd0, '0);
		offer_number(32'h8000_0000, 6'd10, 7'd0, 6'd0, M_SIGN);
		offer_number(32'hFFFF_FFFF, 6'd2, 7'd0, 6'd0, '0);
		offer_number(32'hFFFF_FFFF, 6'd36, 7'd0, 6'd0, M_LOWER);
		offer_number(32'h1234_ABCD, 6'd36, 7'd0, 6'd0, '0);
		// illegal bases on both sides of the range
		offer_number(32'd5, 6'd0, 7'd10, 6'd3, M_ZERO);
		offer_number(32'd5, 6'd1, 7'd0, 6'd0, '0);
		offer_number(32'd5, 6'd37, 7'd0, 6'd0, '0);
		offer_number(32'hFFFF_FFFF, 6'd63, 7'd127, 6'd63, M_ALL);
		// width and digit count at and past their caps
		offer_number(32'd42, 6'd10, 7'd64, 6'd61, '0);
		offer_number(32'd42, 6'd10, 7'd127, 6'd63, M_SIGN | M_PLUS);
		offer_number(32'hFFFF_FFFB, 6'd10, 7'd20, 6'd0, M_LEFT | M_ZERO | M_SIGN);
		offer_number(32'd7, 6'd10, 7'd6, 6'd0, M_PLUS);
		offer_number(32'd7, 6'd10, 7'd6, 6'd0, M_SPACE);
		offer_number(32'hFFFF_FFF9, 6'd10, 7'd6, 6'd0, M_SIGN | M_PLUS | M_SPACE);
		offer_number(32'hFFFF_FFF9, 6'd10, 7'd0, 6'd0, M_PLUS);
		offer_number(32'd0, RADIX_OCT, 7'd0, 6'd0, M_PREF);
		offer_number(32'd0, RADIX_HEX, 7'd0, 6'd0, M_PREF);
		offer_number(32'd255, RADIX_HEX, 7'd12, 6'd0, M_PREF | M_ZERO | M_LOWER | M_SIGN | M_PLUS);
		offer_number(32'd255, RADIX_OCT, 7'd10, 6'd5, M_PREF);
		offer_number(32'd255, 6'd10, 7'd8, 6'd0, M_PREF);
		offer_number(32'h8000_0000, 6'd2, 7'd64, 6'd61, M_ALL);
		offer_number(32'h7FFF_FFFF, RADIX_HEX, 7'd0, 6'd0, M_SIGN);
		offer_number(32'd123, 6'd10, 7'd64, 6'd0, M_LEFT);

		for (int i = 0; i < 110; i++) begin
			if (i == 40) -> hold_go;
			offer_random_number();
		end
		wait_text_drained();

		src_idle_pct = 58;
		snk_idle_pct = 35;
		for (int i = 0; i < 110; i++) offer_random_number();
		wait_text_drained();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		for (int i = 0; i < 115; i++) offer_random_number();
		wait_text_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("formatted %0d numbers over three pacing mixes and a long output stall", n_sent);
		$display("checked %0d text words, %0d mismatches", char_count, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#(4_000_000);
		$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
sv/itf_pkg.sv
sv/itf_if.sv
sv/itf_ctrl.sv
sv/itf_datapath.sv
sv/integer_to_text_formatter_unit.sv
test/itf_text_checker.sv
test/tb_top.sv
